>>> hw/rtl/fpem_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fpem_pkg;
  localparam int InW = 71;
  localparam int OutW = 66;
  localparam int InBytes = 72;
  localparam int OutBytes = 72;
  localparam int Stages = 3;
  localparam logic REQ_EXP = 1'b0;
  localparam logic REQ_MANT = 1'b1;
  localparam logic [1:0] IVL_1_2 = 2'd0;
  localparam logic [1:0] IVL_H_2 = 2'd1;
  localparam logic [1:0] IVL_H_1 = 2'd2;
  localparam logic [1:0] IVL_Q_3 = 2'd3;

  typedef struct packed {
    logic       req_type;
    logic       is_double;
    logic [63:0] operand_bits;
    logic [1:0] interval;
    logic [1:0] sign_control;
    logic       lane_active;
  } item_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
    logic        exp_path;
    logic        neg_exp;
    logic [11:0] mag;
    logic        is_dbl;
    logic        sgn;
    logic [51:0] frac;
    logic [5:0]  lz;
    logic        den_norm;
    logic        odd;
    logic [1:0]  ivl;
    logic        dsign;
    logic        inv;
    logic        den;
  } mid_t;

  function automatic logic [5:0] lead_pos(input logic [51:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 52; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  function automatic logic [3:0] lead12(input logic [11:0] v);
    logic [3:0] p;
    p = '0;
    for (int i = 0; i < 12; i++) begin
      if (v[i]) p = 4'(i);
    end
    return p;
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/fp_exponent_mantissa_extract_top.sv
// an accepted input beat passes through the s1, m and res registers to the output beat
// throughput: one beat per cycle while out_tready does not stall the output, set by the three-stage pipeline
// a stall freezes all stages together, nothing lost
// reset: synchronous active low, clears valid bits and denormals_are_zero
`timescale 1ns / 1ps
`default_nettype none
module fp_exponent_mantissa_extract_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // operand_bits[63:0], interval[1:0], sign_control[1:0], lane_active
  input  wire logic [71:0] in_tdata,
  // req_type, is_double
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // result_bits[63:0], invalid_raised, denormal_raised
  output logic [71:0]      out_tdata
);
  logic daz_r;
  logic en;
  fpem_pkg::item_t it;
  logic [63:0] res;
  logic inv, den;

  always_ff @(posedge clk) begin
    if (!rst_n) daz_r <= 1'b0;
    else if (cfg_we) daz_r <= cfg_wdata;
  end

  assign en = out_tready || !out_tvalid;
  assign in_tready = en;
  assign it.req_type = in_tuser[0];
  assign it.is_double = in_tuser[1];
  assign it.operand_bits = in_tdata[63:0];
  assign it.interval = in_tdata[65:64];
  assign it.sign_control = in_tdata[67:66];
  assign it.lane_active = in_tdata[68];

  fpem_core u_core (
    .clk(clk), .rst_n(rst_n), .en(en), .daz(daz_r),
    .in_vld(in_tvalid), .in_item(it),
    .out_vld(out_tvalid), .out_res(res), .out_inv(inv), .out_den(den)
  );

  assign out_tdata = {6'd0, den, inv, res};
endmodule
`default_nettype wire

>>> hw/rtl/fpem_core.sv
`timescale 1ns / 1ps
`default_nettype none
module fpem_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              daz,
  input  wire logic              in_vld,
  input  wire fpem_pkg::item_t   in_item,
  output logic                   out_vld,
  output logic [63:0]            out_res,
  output logic                   out_inv,
  output logic                   out_den
);
  logic [fpem_pkg::Stages-1:0] vld_r;
  fpem_pkg::item_t s1_r;
  logic s1_daz_r;
  fpem_pkg::mid_t m_nxt, m_r;
  logic [63:0] res_nxt, res_r;
  logic inv_r, den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[fpem_pkg::Stages-2:0], in_vld};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= in_item;
      s1_daz_r <= daz;
      m_r <= m_nxt;
      res_r <= res_nxt;
      inv_r <= m_r.inv;
      den_r <= m_r.den;
    end
  end

  // stage 2: classify, leading one
  always_comb begin
    logic dbl, sg, fzero, emax, eraw0, quiet, neg;
    logic [10:0] raw;
    logic [51:0] fr;
    logic [63:0] x, one, qn, expm, signb, indef;
    logic signed [12:0] e;
    logic [5:0] tp;
    logic [10:0] bias;
    dbl = s1_r.is_double;
    x = dbl ? s1_r.operand_bits : {32'd0, s1_r.operand_bits[31:0]};
    raw = dbl ? x[62:52] : {3'd0, x[30:23]};
    fr = dbl ? x[51:0] : {29'd0, x[22:0]};
    sg = dbl ? x[63] : x[31];
    bias = dbl ? 11'd1023 : 11'd127;
    emax = dbl ? (raw == 11'h7ff) : (raw == 11'h0ff);
    eraw0 = raw == 11'd0;
    fzero = fr == 52'd0;
    quiet = dbl ? fr[51] : fr[22];
    qn = dbl ? (x | 64'h0008000000000000) : (x | 64'h00400000);
    expm = dbl ? 64'h7ff0000000000000 : 64'h7f800000;
    signb = dbl ? 64'h8000000000000000 : 64'h80000000;
    indef = dbl ? 64'hfff8000000000000 : 64'hffc00000;
    neg = sg;
    tp = fpem_pkg::lead_pos(fr);
    m_nxt = '0;
    m_nxt.is_dbl = dbl;
    m_nxt.sgn = sg;
    m_nxt.frac = fr;
    m_nxt.ivl = s1_r.interval;
    m_nxt.dsign = s1_r.sign_control[0] ? 1'b0 : sg;
    one = (m_nxt.dsign ? signb : 64'd0) | (dbl ? {1'b0, 11'd1023, 52'd0} : {33'd0, 8'd127, 23'd0});
    m_nxt.lz = (dbl ? 6'd52 : 6'd23) - tp;
    m_nxt.den_norm = eraw0;
    if (eraw0) begin
      e = 13'(tp) + 13'sd1 - 13'(bias) - (dbl ? 13'sd52 : 13'sd23);
      m_nxt.odd = m_nxt.lz[0];
    end else begin
      e = 13'(raw) - 13'(bias);
      m_nxt.odd = e[0];
    end
    m_nxt.neg_exp = e[12];
    m_nxt.mag = e[12] ? 12'(-e) : e[11:0];
    if (!s1_r.lane_active) begin
      m_nxt.done = 1'b1;
    end else if (emax && !fzero) begin
      m_nxt.done = 1'b1; m_nxt.res = qn; m_nxt.inv = !quiet;
    end else if (s1_r.req_type == fpem_pkg::REQ_EXP) begin
      if (emax) begin
        m_nxt.done = 1'b1; m_nxt.res = expm;
      end else if (eraw0 && (fzero || s1_daz_r)) begin
        m_nxt.done = 1'b1; m_nxt.res = signb | expm;
      end else begin
        m_nxt.exp_path = 1'b1; m_nxt.den = eraw0;
      end
    end else begin
      if (eraw0 && (fzero || s1_daz_r)) begin
        m_nxt.done = 1'b1; m_nxt.res = one;
      end else if (neg && s1_r.sign_control[1]) begin
        m_nxt.done = 1'b1; m_nxt.res = indef; m_nxt.inv = 1'b1;
      end else if (emax) begin
        m_nxt.done = 1'b1; m_nxt.res = one;
      end else begin
        m_nxt.den = eraw0;
      end
    end
  end

  // stage 3: build result
  always_comb begin
    logic [3:0] p;
    logic [11:0] mexp, msk;
    logic [51:0] fr, fm;
    logic [10:0] de;
    logic dec;
    res_nxt = m_r.res;
    if (!m_r.done) begin
      if (m_r.exp_path) begin
        p = fpem_pkg::lead12(m_r.mag);
        msk = 12'((13'd1 << p) - 13'd1);
        if (m_r.mag == 12'd0) begin
          res_nxt = '0;
        end else if (m_r.is_dbl) begin
          fm = {m_r.mag & msk, 40'd0} << (6'd12 - 6'(p));
          mexp = 12'd1023 + 12'(p);
          res_nxt = {m_r.neg_exp, mexp[10:0], fm};
        end else begin
          fm = {29'd0, 11'd0, m_r.mag & msk} << (6'd23 - 6'(p));
          mexp = 12'd127 + 12'(p);
          res_nxt = {32'd0, m_r.neg_exp, mexp[7:0], fm[22:0]};
        end
      end else begin
        fr = m_r.den_norm ? (m_r.frac << m_r.lz) : m_r.frac;
        fr = m_r.is_dbl ? fr : {29'd0, fr[22:0]};
        case (m_r.ivl)
          fpem_pkg::IVL_H_2: dec = m_r.odd;
          fpem_pkg::IVL_H_1: dec = 1'b1;
          fpem_pkg::IVL_Q_3: dec = m_r.is_dbl ? fr[51] : fr[22];
          default: dec = 1'b0;
        endcase
        de = (m_r.is_dbl ? 11'd1023 : 11'd127) - 11'(dec);
        if (m_r.is_dbl) res_nxt = {m_r.dsign, de, fr};
        else res_nxt = {32'd0, m_r.dsign, de[7:0], fr[22:0]};
      end
    end
  end

  assign out_vld = vld_r[fpem_pkg::Stages-1];
  assign out_res = res_r;
  assign out_inv = inv_r;
  assign out_den = den_r;
endmodule
`default_nettype wire

>>> hw/rtl/fpem_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module fpem_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [71:0] in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [71:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("hold");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("ready");
  a_mask: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tdata[68] && out_tready ##1 out_tready ##1 out_tready
    |=> out_tvalid && out_tdata == 72'd0) else $error("mask");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[71:66] == 6'd0) else $error("pad");
endmodule
bind fp_exponent_mantissa_extract_top fpem_checker u_chk (.*);
`default_nettype wire

>>> tb/tb_fp_exponent_mantissa_extract_top.sv
`timescale 1ns / 1ps

class ExtractScoreboard;
  logic [65:0] pending[$];
  int unsigned errors;
  int unsigned checked;

  function new();
    errors = 0;
    checked = 0;
  endfunction

  static function int unsigned top_bit(logic [63:0] v);
    int unsigned p;
    p = 0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) p = i;
    end
    return p;
  endfunction

  static function logic [63:0] int_to_float(int e, bit dbl);
    logic [63:0] s, m, fmask;
    int unsigned p, fb, bias;
    fb = dbl ? 52 : 23;
    bias = dbl ? 1023 : 127;
    fmask = dbl ? 64'h000f_ffff_ffff_ffff : 64'h007f_ffff;
    if (e == 0) return '0;
    s = '0;
    if (e < 0) begin
      s = dbl ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
      m = 64'(-e);
    end else begin
      m = 64'(e);
    end
    p = top_bit(m);
    return s | (64'(bias + p) << fb) | ((m << (fb - p)) & fmask);
  endfunction

  // expected {denormal, invalid, result} for one beat
  static function logic [65:0] extract(logic [70:0] beat, bit daz);
    logic req, dbl, act, neg, inv, den;
    logic [1:0] ivl, sc;
    logic [63:0] x, sgn, emask, fmask, quiet, indef, wmask, frac, dsign, one, r;
    int unsigned fb, bias, maxexp, raw, dexp, shift, parity;
    req = beat[0];
    dbl = beat[1];
    ivl = beat[67:66];
    sc = beat[69:68];
    act = beat[70];
    fb = dbl ? 52 : 23;
    bias = dbl ? 1023 : 127;
    maxexp = dbl ? 'h7ff : 'hff;
    sgn = dbl ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
    emask = dbl ? 64'h7ff0_0000_0000_0000 : 64'h7f80_0000;
    fmask = dbl ? 64'h000f_ffff_ffff_ffff : 64'h007f_ffff;
    quiet = dbl ? 64'h0008_0000_0000_0000 : 64'h0040_0000;
    indef = dbl ? 64'hfff8_0000_0000_0000 : 64'hffc0_0000;
    wmask = dbl ? '1 : 64'hffff_ffff;
    x = beat[65:2] & wmask;
    inv = 0;
    den = 0;
    r = '0;
    raw = 32'((x & emask) >> fb);
    frac = x & fmask;
    if (act) begin
      if (req == fpem_pkg::REQ_EXP) begin
        if (raw == maxexp) begin
          if (frac == 0) r = emask;
          else begin
            inv = (frac & quiet) == 0;
            r = x | quiet;
          end
        end else if (raw == 0) begin
          if (frac == 0 || daz) r = sgn | emask;
          else begin
            den = 1;
            r = int_to_float(int'(top_bit(frac)) + 1 - int'(bias) - int'(fb), dbl);
          end
        end else begin
          r = int_to_float(int'(raw) - int'(bias), dbl);
        end
      end else begin
        neg = (x & sgn) != 0;
        dsign = sc[0] ? '0 : (x & sgn);
        one = dsign | (64'(bias) << fb);
        dexp = bias;
        if (raw == maxexp && frac != 0) begin
          inv = (frac & quiet) == 0;
          r = x | quiet;
        end else if (raw == 0 && (frac == 0 || daz)) begin
          r = one;
        end else if (neg && sc[1]) begin
          inv = 1;
          r = indef;
        end else if (raw == maxexp) begin
          r = one;
        end else begin
          if (raw == 0) begin
            shift = fb - top_bit(frac);
            den = 1;
            frac = (frac << shift) & fmask;
            parity = shift & 1;
          end else begin
            parity = (raw - bias) & 1;
          end
          case (ivl)
            fpem_pkg::IVL_H_2: if (parity != 0) dexp--;
            fpem_pkg::IVL_H_1: dexp--;
            fpem_pkg::IVL_Q_3: if (frac[fb-1]) dexp--;
            default: ;
          endcase
          r = dsign | (64'(dexp) << fb) | frac;
        end
      end
      r &= wmask;
    end
    return {den, inv, r};
  endfunction

  function void note(logic [70:0] beat, bit daz);
    pending.push_back(extract(beat, daz));
  endfunction

  function void check(logic [65:0] got);
    logic [65:0] want;
    checked++;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected output beat %h", got);
      return;
    end
    want = pending.pop_front();
    if (got[63:0] !== want[63:0] || got[64] !== want[64] || got[65] !== want[65]) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: result %h inv %b den %b, expected %h inv %b den %b",
                 got[63:0], got[64], got[65], want[63:0], want[64], want[65]);
    end
  endfunction
endclass

module tb_fp_exponent_mantissa_extract_top;
  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic cfg_wdata = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [71:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [71:0] out_tdata;

  ExtractScoreboard board = new();
  bit daz = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  bit hold_req = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_sent = 0;

  always #5 clk = ~clk;

  fp_exponent_mantissa_extract_top DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // monitors, receiver pacing, watchdog
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) board.note({in_tdata[68:0], in_tuser}, daz);
    if (rst_n && out_tvalid && out_tready) board.check(out_tdata[65:0]);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("fp_exponent_mantissa_extract_top test failed");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_tready <= 0;
        for (n = 0; n < 300; n++) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_beat(logic req, logic dbl, logic [63:0] op, logic [1:0] ivl,
                           logic [1:0] sc, logic act);
    if ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {3'b0, act, sc, ivl, op};
    in_tuser <= {dbl, req};
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  task automatic drain_and_set(bit v);
    in_tvalid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    daz = v;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand_operand(bit dbl);
    logic [63:0] v, s;
    int unsigned fb, cls;
    logic [63:0] emask, fmask, quiet;
    v = {$urandom, $urandom};
    fb = dbl ? 52 : 23;
    emask = dbl ? 64'h7ff0_0000_0000_0000 : 64'h7f80_0000;
    fmask = dbl ? 64'h000f_ffff_ffff_ffff : 64'h007f_ffff;
    quiet = dbl ? 64'h0008_0000_0000_0000 : 64'h0040_0000;
    s = v & (dbl ? 64'h8000_0000_0000_0000 : 64'h8000_0000);
    cls = $urandom_range(9);
    case (cls)
      0: v = (v & ~(emask | fmask));
      1: v = (v & ~emask) | (dbl ? 64'h1 : 64'h1) << $urandom_range(fb - 1);
      2: v = v & ~emask;
      3: v = (v & ~fmask) | emask;
      4: v = v | emask | quiet;
      5: v = ((v | emask) & ~quiet) | (64'h1 << $urandom_range(fb - 2));
      default: ;
    endcase
    return v | s;
  endfunction

  task automatic random_burst(int unsigned cnt, bit with_hold);
    bit dbl;
    for (int i = 0; i < cnt; i++) begin
      if (with_hold && i == 20) hold_req = 1;
      dbl = $urandom_range(1);
      send_beat($urandom_range(1), dbl, rand_operand(dbl), $urandom_range(3),
                $urandom_range(3), $urandom_range(7) != 0);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    drain_and_set(0);
    send_idle = 15;
    recv_idle = 80;
    // directed extremes and special cases
    send_beat(fpem_pkg::REQ_EXP, 1, 64'h0, fpem_pkg::IVL_1_2, 2'd0, 1);
    send_beat(fpem_pkg::REQ_EXP, 1, 64'h8000_0000_0000_0001, fpem_pkg::IVL_1_2, 2'd3, 1);
    send_beat(fpem_pkg::REQ_EXP, 1, 64'h7ff0_0000_0000_0000, fpem_pkg::IVL_1_2, 2'd0, 1);
    send_beat(fpem_pkg::REQ_EXP, 1, 64'h7ff0_0000_0000_0001, fpem_pkg::IVL_1_2, 2'd0, 1);
    send_beat(fpem_pkg::REQ_EXP, 1, 64'hfff8_0000_0000_0000, fpem_pkg::IVL_1_2, 2'd0, 1);
    send_beat(fpem_pkg::REQ_EXP, 1, 64'h7fef_ffff_ffff_ffff, fpem_pkg::IVL_Q_3, 2'd3, 1);
    send_beat(fpem_pkg::REQ_EXP, 0, 64'hffff_ffff_0000_0001, fpem_pkg::IVL_1_2, 2'd0, 1);
    send_beat(fpem_pkg::REQ_EXP, 0, 64'h0000_0000_3f80_0000, fpem_pkg::IVL_1_2, 2'd0, 1);
    send_beat(fpem_pkg::REQ_EXP, 0, 64'h0000_0000_ff80_0000, fpem_pkg::IVL_1_2, 2'd0, 1);
    send_beat(fpem_pkg::REQ_EXP, 0, 64'h0000_0000_7f80_0001, fpem_pkg::IVL_1_2, 2'd0, 1);
    send_beat(fpem_pkg::REQ_MANT, 1, 64'h8000_0000_0000_0000, fpem_pkg::IVL_H_2, 2'd2, 1);
    send_beat(fpem_pkg::REQ_MANT, 1, 64'hfff0_0000_0000_0000, fpem_pkg::IVL_1_2, 2'd2, 1);
    send_beat(fpem_pkg::REQ_MANT, 1, 64'hfff0_0000_0000_0000, fpem_pkg::IVL_1_2, 2'd1, 1);
    send_beat(fpem_pkg::REQ_MANT, 1, 64'hc008_0000_0000_0000, fpem_pkg::IVL_H_2, 2'd2, 1);
    send_beat(fpem_pkg::REQ_MANT, 1, 64'hc008_0000_0000_0000, fpem_pkg::IVL_H_1, 2'd0, 1);
    send_beat(fpem_pkg::REQ_MANT, 1, 64'h400c_0000_0000_0000, fpem_pkg::IVL_Q_3, 2'd1, 1);
    send_beat(fpem_pkg::REQ_MANT, 1, 64'h0000_0000_0000_0003, fpem_pkg::IVL_H_2, 2'd0, 1);
    send_beat(fpem_pkg::REQ_MANT, 0, 64'h0000_0000_0000_0001, fpem_pkg::IVL_Q_3, 2'd0, 1);
    send_beat(fpem_pkg::REQ_MANT, 0, 64'h0000_0000_ff80_0001, fpem_pkg::IVL_1_2, 2'd0, 1);
    send_beat(fpem_pkg::REQ_MANT, 0, 64'hffff_ffff_c0ff_ffff, fpem_pkg::IVL_H_2, 2'd3, 1);
    send_beat(fpem_pkg::REQ_MANT, 1, 64'hffff_ffff_ffff_ffff, fpem_pkg::IVL_Q_3, 2'd3, 0);
    drain_and_set(1);
    send_beat(fpem_pkg::REQ_EXP, 1, 64'h000f_ffff_ffff_ffff, fpem_pkg::IVL_1_2, 2'd0, 1);
    send_beat(fpem_pkg::REQ_MANT, 0, 64'h0000_0000_807f_ffff, fpem_pkg::IVL_1_2, 2'd2, 1);
    random_burst(230, 0);
    drain_and_set(0);
    send_idle = 80;
    recv_idle = 15;
    random_burst(250, 0);
    drain_and_set(1);
    send_idle = 0;
    recv_idle = 0;
    random_burst(250, 1);
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("sent %0d beats, checked %0d results across both formats and both ops",
             n_sent, board.checked);
    $display("denormals-are-zero toggled, three pacing modes plus a long output stall");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("fp_exponent_mantissa_extract_top test passed");
    end else begin
      $display("fp_exponent_mantissa_extract_top test failed");
    end
    $finish;
  end
endmodule

>>> filelist.f
hw/rtl/fpem_pkg.sv
hw/rtl/fpem_core.sv
hw/rtl/fp_exponent_mantissa_extract_top.sv
hw/rtl/fpem_checker.sv
tb/tb_fp_exponent_mantissa_extract_top.sv
